FILE: design/dccpr_pkg.sv
// ----------------------------------------------------------------------------
// dccpr_pkg
// Shared types and constants of the DCC packet receiver: input and output
// words, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package dccpr_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] CfgOneMin       = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgOneMax       = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgZeroMin      = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgZeroMax      = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgPreambleMin  = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CfgTimeoutLimit = 3'd5;

  localparam logic [15:0] OneMinReset       = 16'd220;
  localparam logic [15:0] OneMaxReset       = 16'd375;
  localparam logic [15:0] ZeroMinReset      = 16'd425;
  localparam logic [15:0] ZeroMaxReset      = 16'd50000;
  localparam logic [5:0]  PreambleMinReset  = 6'd10;
  localparam logic [15:0] TimeoutLimitReset = 16'd800;

  localparam logic [5:0] PreambleSat = 6'd32;
  localparam int unsigned MinPacket  = 3;
  localparam logic [3:0] DataBits    = 4'd8;

  localparam logic CmdPulse = 1'b0;
  localparam logic CmdTick  = 1'b1;

  localparam logic KindStatus = 1'b0;
  localparam logic KindByte   = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] pulse_width;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic       last;
    logic       analog_mode;
  } out_word_t;

endpackage

`default_nettype wire

FILE: design/dccpr_ram.sv
// ----------------------------------------------------------------------------
// dccpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dccpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/dcc_packet_receiver.sv
// ----------------------------------------------------------------------------
// dcc_packet_receiver
// DCC bit classification, packet framing, checksum test, byte readout and tick status.
// ----------------------------------------------------------------------------
// Each input word is a measured pulse width or a timer tick. A tick yields
// one status word. A pulse of width zero is dropped; any other pulse is
// classed against the four window registers by a single shared 16-bit
// comparator, one bound a cycle. A closing end bit of a good packet then
// reads the packet back from the byte store, each byte passing the
// registered read port and then the output register. The input stalls
// while a word is in work; a finished output word may wait in the output
// register while the next input word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_packet_receiver #(
  parameter int unsigned PACKET_BYTES = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire dccpr_pkg::in_word_t                 in_word_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output dccpr_pkg::out_word_t                     out_word_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [dccpr_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [dccpr_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  import dccpr_pkg::*;

  localparam int unsigned AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int unsigned CW = $clog2(PACKET_BYTES + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_TSTAT,
    S_C1,
    S_C2,
    S_C3,
    S_C4,
    S_FRAME,
    S_RD,
    S_OUT
  } state_e;

  state_e state_q;

  logic [15:0] one_min_q, one_max_q, zero_min_q, zero_max_q, timeout_limit_q;
  logic [5:0]  preamble_min_q;

  logic [15:0]   width_q;
  logic          win_q;
  logic          bit_q;
  logic          in_packet_q;
  logic [5:0]    preamble_count_q;
  logic [3:0]    bit_pos_q;
  logic [CW-1:0] byte_count_q;
  logic [7:0]    shift_byte_q;
  logic [7:0]    running_xor_q;
  logic [15:0]   timeout_q;
  logic [AW-1:0] rd_idx_q;

  logic          out_valid_q;
  out_word_t     out_q;

  logic [15:0]   cmp_a, cmp_b;
  logic          cmp_gt;
  logic          out_free;
  logic          store_we;
  logic [7:0]    ram_rdata;
  logic [7:0]    xor_new;
  logic [CW-1:0] count_new;
  logic          rd_last;

  always_comb begin
    unique case (state_q) inside
      S_C1:             begin cmp_a = width_q;         cmp_b = one_min_q;  end
      S_C2:             begin cmp_a = one_max_q;       cmp_b = width_q;    end
      S_C3:             begin cmp_a = width_q;         cmp_b = zero_min_q; end
      S_C4:             begin cmp_a = zero_max_q;      cmp_b = width_q;    end
      S_TICK, S_TSTAT:  begin cmp_a = timeout_limit_q; cmp_b = timeout_q;  end
      default:          begin cmp_a = width_q;         cmp_b = one_min_q;  end
    endcase
  end

  assign cmp_gt    = cmp_a > cmp_b;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign xor_new   = running_xor_q ^ shift_byte_q;
  assign count_new = byte_count_q + CW'(1);
  assign rd_last   = (CW'(rd_idx_q) + CW'(1)) == byte_count_q;
  assign store_we  = (state_q == S_FRAME) && in_packet_q && (bit_pos_q >= DataBits)
                     && (byte_count_q < CW'(PACKET_BYTES));

  dccpr_ram #(
    .Width (8),
    .Depth (PACKET_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (byte_count_q[AW-1:0]),
    .wdata_i (shift_byte_q),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      one_min_q        <= OneMinReset;
      one_max_q        <= OneMaxReset;
      zero_min_q       <= ZeroMinReset;
      zero_max_q       <= ZeroMaxReset;
      preamble_min_q   <= PreambleMinReset;
      timeout_limit_q  <= TimeoutLimitReset;
      in_packet_q      <= 1'b0;
      preamble_count_q <= '0;
      bit_pos_q        <= '0;
      byte_count_q     <= '0;
      shift_byte_q     <= '0;
      running_xor_q    <= '0;
      timeout_q        <= '0;
      rd_idx_q         <= '0;
      win_q            <= 1'b0;
      bit_q            <= 1'b0;
      width_q          <= '0;
      out_valid_q      <= 1'b0;
      out_q            <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgOneMin:       one_min_q       <= cfg_data_i;
          CfgOneMax:       one_max_q       <= cfg_data_i;
          CfgZeroMin:      zero_min_q      <= cfg_data_i;
          CfgZeroMax:      zero_max_q      <= cfg_data_i;
          CfgPreambleMin:  preamble_min_q  <= cfg_data_i[5:0];
          CfgTimeoutLimit: timeout_limit_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && state_q != S_TSTAT && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            width_q <= in_word_i.pulse_width;
            if (in_word_i.command == CmdTick) begin
              state_q <= S_TICK;
            end else if (in_word_i.pulse_width != '0) begin
              state_q <= S_C1;
            end
          end
        end
        S_TICK: begin
          if (cmp_gt) begin
            timeout_q <= timeout_q + 16'd1;
          end
          state_q <= S_TSTAT;
        end
        S_TSTAT: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_q.kind        <= KindStatus;
            out_q.data_byte   <= '0;
            out_q.byte_index  <= '0;
            out_q.last        <= 1'b0;
            out_q.analog_mode <= !cmp_gt;
            state_q           <= S_IDLE;
          end
        end
        S_C1: begin
          win_q   <= cmp_gt;
          state_q <= S_C2;
        end
        S_C2: begin
          if (win_q && cmp_gt) begin
            bit_q   <= 1'b1;
            state_q <= S_FRAME;
          end else begin
            state_q <= S_C3;
          end
        end
        S_C3: begin
          win_q   <= cmp_gt;
          state_q <= S_C4;
        end
        S_C4: begin
          if (win_q && cmp_gt) begin
            bit_q   <= 1'b0;
            state_q <= S_FRAME;
          end else begin
            in_packet_q      <= 1'b0;
            preamble_count_q <= '0;
            bit_pos_q        <= '0;
            byte_count_q     <= '0;
            shift_byte_q     <= '0;
            running_xor_q    <= '0;
            state_q          <= S_IDLE;
          end
        end
        S_FRAME: begin
          if (!in_packet_q) begin
            state_q <= S_IDLE;
            if (bit_q) begin
              if (preamble_count_q < PreambleSat) begin
                preamble_count_q <= preamble_count_q + 6'd1;
              end
            end else begin
              if (preamble_count_q >= preamble_min_q) begin
                in_packet_q   <= 1'b1;
                bit_pos_q     <= '0;
                byte_count_q  <= '0;
                shift_byte_q  <= '0;
                running_xor_q <= '0;
              end
              preamble_count_q <= '0;
            end
          end else if (bit_pos_q < DataBits) begin
            shift_byte_q <= {shift_byte_q[6:0], bit_q};
            bit_pos_q    <= bit_pos_q + 4'd1;
            state_q      <= S_IDLE;
          end else if (byte_count_q >= CW'(PACKET_BYTES)) begin
            in_packet_q      <= 1'b0;
            preamble_count_q <= '0;
            bit_pos_q        <= '0;
            byte_count_q     <= '0;
            shift_byte_q     <= '0;
            running_xor_q    <= '0;
            state_q          <= S_IDLE;
          end else if (!bit_q) begin
            running_xor_q <= xor_new;
            byte_count_q  <= count_new;
            shift_byte_q  <= '0;
            bit_pos_q     <= '0;
            state_q       <= S_IDLE;
          end else if (xor_new == '0 && count_new >= CW'(MinPacket)) begin
            byte_count_q <= count_new;
            timeout_q    <= '0;
            rd_idx_q     <= '0;
            state_q      <= S_RD;
          end else begin
            in_packet_q      <= 1'b0;
            preamble_count_q <= '0;
            bit_pos_q        <= '0;
            byte_count_q     <= '0;
            shift_byte_q     <= '0;
            running_xor_q    <= '0;
            state_q          <= S_IDLE;
          end
        end
        S_RD: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_q.kind        <= KindByte;
            out_q.data_byte   <= ram_rdata;
            out_q.byte_index  <= 5'(rd_idx_q);
            out_q.last        <= rd_last;
            out_q.analog_mode <= (timeout_limit_q == '0);
            if (rd_last) begin
              in_packet_q      <= 1'b0;
              preamble_count_q <= '0;
              bit_pos_q        <= '0;
              byte_count_q     <= '0;
              shift_byte_q     <= '0;
              running_xor_q    <= '0;
              state_q          <= S_IDLE;
            end else begin
              rd_idx_q <= rd_idx_q + AW'(1);
              state_q  <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
